// ===== sv/script_token_lexer_assert.svh =====
// Assertion macros shared by the script token lexer modules.
`ifndef SCRIPT_TOKEN_LEXER_ASSERT_SVH
`define SCRIPT_TOKEN_LEXER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define STL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define STL_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/stl_pkg.sv =====
// Types, codes, character constants and helpers of the script token lexer.
package stl_pkg;

  localparam int unsigned POS_BITS_DEF = 16;

  // Result slots filled by one input item: held char, final char, end of string.
  localparam int unsigned NumSlots = 6;
  localparam int unsigned SlotIdxW = $clog2(NumSlots);

  // Lexer modes
  localparam logic [2:0] ModeUndef   = 3'd0;
  localparam logic [2:0] ModeString  = 3'd1;
  localparam logic [2:0] ModeIdent   = 3'd2;
  localparam logic [2:0] ModeNumber  = 3'd3;
  localparam logic [2:0] ModeComment = 3'd4;

  // Token kinds
  localparam logic [3:0] KindNumber  = 4'd0;
  localparam logic [3:0] KindWord    = 4'd1;
  localparam logic [3:0] KindDeclare = 4'd2;
  localparam logic [3:0] KindAssign  = 4'd3;
  localparam logic [3:0] KindString  = 4'd4;
  localparam logic [3:0] KindSqOpen  = 4'd5;
  localparam logic [3:0] KindSqClose = 4'd6;
  localparam logic [3:0] KindCuOpen  = 4'd7;
  localparam logic [3:0] KindCuClose = 4'd8;
  localparam logic [3:0] KindEnd     = 4'd9;
  localparam logic [3:0] KindError   = 4'd10;

  // Identifier kinds held in state (low bits of the token kind)
  localparam logic [1:0] IdWord    = 2'd1;
  localparam logic [1:0] IdDeclare = 2'd2;
  localparam logic [1:0] IdAssign  = 2'd3;

  // Error codes
  localparam logic [2:0] ErrNone        = 3'd0;
  localparam logic [2:0] ErrQuoteAtEnd  = 3'd1;
  localparam logic [2:0] ErrNoIdDeclare = 3'd2;
  localparam logic [2:0] ErrNoIdAssign  = 3'd3;
  localparam logic [2:0] ErrUnterm      = 3'd4;
  localparam logic [2:0] ErrBadChar     = 3'd5;
  localparam logic [2:0] ErrTooLong     = 3'd6;

  // Code points
  localparam logic [20:0] ChUnder   = 21'h5F;
  localparam logic [20:0] ChDollar  = 21'h24;
  localparam logic [20:0] ChHash    = 21'h23;
  localparam logic [20:0] ChEq      = 21'h3D;
  localparam logic [20:0] ChSqOpen  = 21'h5B;
  localparam logic [20:0] ChSqClose = 21'h5D;
  localparam logic [20:0] ChCuOpen  = 21'h7B;
  localparam logic [20:0] ChCuClose = 21'h7D;
  localparam logic [20:0] ChNewline = 21'h0A;
  localparam logic [20:0] ChQuote   = 21'h22;
  localparam logic [20:0] ChBslash  = 21'h5C;
  localparam logic [20:0] ChPlus    = 21'h2B;
  localparam logic [20:0] ChMinus   = 21'h2D;
  localparam logic [20:0] ChComma   = 21'h2C;
  localparam logic [20:0] ChPercent = 21'h25;
  localparam logic [20:0] ChBang    = 21'h21;
  localparam logic [20:0] ChLess    = 21'h3C;
  localparam logic [20:0] ChGreater = 21'h3E;
  localparam logic [20:0] ChSpace   = 21'h20;
  localparam logic [20:0] ChTab     = 21'h09;
  localparam logic [20:0] ChCr      = 21'h0D;
  localparam logic [20:0] ChDig0    = 21'h30;
  localparam logic [20:0] ChDig9    = 21'h39;
  localparam logic [20:0] ChLowA    = 21'h61;
  localparam logic [20:0] ChLowZ    = 21'h7A;
  localparam logic [20:0] ChUpA     = 21'h41;
  localparam logic [20:0] ChUpZ     = 21'h5A;

  typedef struct packed {
    logic [20:0] char_code;
    logic        final_char;
  } lex_in_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] start_pos;
    logic [15:0] token_length;
    logic [2:0]  error_code;
    logic        run_end;
  } tok_out_t;

  typedef struct packed {
    logic     vld;
    tok_out_t tok;
  } slot_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] ikind;
    logic       skip;
  } lex_ctl_t;

  function automatic logic is_digit(logic [20:0] c);
    return c inside {[ChDig0:ChDig9]};
  endfunction

  function automatic logic is_start(logic [20:0] c);
    return (c == ChUnder) || (c inside {[ChLowA:ChLowZ]}) || (c inside {[ChUpA:ChUpZ]});
  endfunction

  function automatic logic is_ident(logic [20:0] c);
    return is_start(c) || is_digit(c);
  endfunction

  function automatic logic is_space(logic [20:0] c);
    return c inside {ChSpace, ChTab, ChNewline, ChCr};
  endfunction

  function automatic slot_t tok(logic [3:0] kind, logic [15:0] start,
                                logic [15:0] len, logic [2:0] code);
    slot_t s;
    s.vld              = 1'b1;
    s.tok.token_kind   = kind;
    s.tok.start_pos    = start;
    s.tok.token_length = len;
    s.tok.error_code   = code;
    s.tok.run_end      = 1'b0;
    return s;
  endfunction

endpackage

// ===== sv/stl_lex_char.sv =====
// Decision for one character with one character of lookahead.
module stl_lex_char #(
  parameter int unsigned POS_BITS = stl_pkg::POS_BITS_DEF
) (
  input  logic [20:0]           char_i,
  input  logic [20:0]           look_i,
  input  logic                  look_vld_i,
  input  logic [POS_BITS-1:0]   pos_i,
  input  stl_pkg::lex_ctl_t     ctl_i,
  input  logic [POS_BITS-1:0]   tstart_i,
  output stl_pkg::lex_ctl_t     ctl_o,
  output logic [POS_BITS-1:0]   tstart_o,
  output logic                  fail_o,
  output stl_pkg::slot_t [1:0]  res_o
);

  logic [POS_BITS-1:0] pos_inc;
  logic [15:0]         pos16;
  logic [15:0]         run_len;
  logic                eq_next;
  logic                dispatch;

  assign pos_inc = pos_i + POS_BITS'(1);
  assign pos16   = 16'(pos_i);
  assign run_len = 16'(pos_i - tstart_i);
  assign eq_next = look_vld_i && (look_i == stl_pkg::ChEq);

  always_comb begin
    ctl_o    = ctl_i;
    tstart_o = tstart_i;
    fail_o   = 1'b0;
    res_o    = '0;
    dispatch = 1'b0;
    if (ctl_i.skip) begin
      ctl_o.skip = 1'b0;
    end else begin
      case (ctl_i.mode)
        stl_pkg::ModeString: begin
          if (char_i == stl_pkg::ChQuote) begin
            res_o[0]   = stl_pkg::tok(stl_pkg::KindString, 16'(tstart_i), run_len,
                                      stl_pkg::ErrNone);
            ctl_o.mode = stl_pkg::ModeUndef;
          end else if (char_i == stl_pkg::ChBslash && look_vld_i &&
                       look_i == stl_pkg::ChQuote) begin
            ctl_o.skip = 1'b1;
          end
        end
        stl_pkg::ModeIdent: begin
          if (!stl_pkg::is_ident(char_i)) begin
            res_o[0]   = stl_pkg::tok({2'b00, ctl_i.ikind}, 16'(tstart_i), run_len,
                                      stl_pkg::ErrNone);
            ctl_o.mode = stl_pkg::ModeUndef;
            dispatch   = 1'b1;
          end
        end
        stl_pkg::ModeNumber: begin
          if (!stl_pkg::is_digit(char_i)) begin
            res_o[0]   = stl_pkg::tok(stl_pkg::KindNumber, 16'(tstart_i), run_len,
                                      stl_pkg::ErrNone);
            ctl_o.mode = stl_pkg::ModeUndef;
            dispatch   = 1'b1;
          end
        end
        stl_pkg::ModeComment: begin
          if (char_i == stl_pkg::ChNewline) ctl_o.mode = stl_pkg::ModeUndef;
        end
        default: begin
          ctl_o.mode = stl_pkg::ModeUndef;
          dispatch   = 1'b1;
        end
      endcase

      if (dispatch) begin
        if (stl_pkg::is_digit(char_i)) begin
          ctl_o.mode = stl_pkg::ModeNumber;
          tstart_o   = pos_i;
        end else if (stl_pkg::is_start(char_i)) begin
          ctl_o.mode  = stl_pkg::ModeIdent;
          ctl_o.ikind = stl_pkg::IdWord;
          tstart_o    = pos_i;
        end else if (char_i == stl_pkg::ChQuote) begin
          if (!look_vld_i) begin
            res_o[1] = stl_pkg::tok(stl_pkg::KindError, pos16, 16'd0,
                                    stl_pkg::ErrQuoteAtEnd);
            fail_o   = 1'b1;
          end else begin
            ctl_o.mode = stl_pkg::ModeString;
            tstart_o   = pos_inc;
          end
        end else if (char_i == stl_pkg::ChSqOpen) begin
          res_o[1] = stl_pkg::tok(stl_pkg::KindSqOpen, pos16, 16'd0, stl_pkg::ErrNone);
        end else if (char_i == stl_pkg::ChSqClose) begin
          res_o[1] = stl_pkg::tok(stl_pkg::KindSqClose, pos16, 16'd0, stl_pkg::ErrNone);
        end else if (char_i == stl_pkg::ChCuOpen) begin
          res_o[1] = stl_pkg::tok(stl_pkg::KindCuOpen, pos16, 16'd0, stl_pkg::ErrNone);
        end else if (char_i == stl_pkg::ChCuClose) begin
          res_o[1] = stl_pkg::tok(stl_pkg::KindCuClose, pos16, 16'd0, stl_pkg::ErrNone);
        end else if (char_i inside {stl_pkg::ChPlus, stl_pkg::ChMinus,
                                    stl_pkg::ChComma, stl_pkg::ChPercent}) begin
          res_o[1] = stl_pkg::tok(stl_pkg::KindWord, pos16, 16'd1, stl_pkg::ErrNone);
        end else if (char_i inside {stl_pkg::ChBang, stl_pkg::ChLess,
                                    stl_pkg::ChGreater}) begin
          res_o[1]   = stl_pkg::tok(stl_pkg::KindWord, pos16, eq_next ? 16'd2 : 16'd1,
                                    stl_pkg::ErrNone);
          ctl_o.skip = eq_next;
        end else if (char_i == stl_pkg::ChEq && eq_next) begin
          res_o[1]   = stl_pkg::tok(stl_pkg::KindWord, pos16, 16'd2, stl_pkg::ErrNone);
          ctl_o.skip = 1'b1;
        end else if (char_i == stl_pkg::ChDollar || char_i == stl_pkg::ChEq) begin
          if (!look_vld_i || !stl_pkg::is_start(look_i)) begin
            res_o[1] = stl_pkg::tok(stl_pkg::KindError, pos16, 16'd0,
                                    (char_i == stl_pkg::ChDollar) ?
                                    stl_pkg::ErrNoIdDeclare : stl_pkg::ErrNoIdAssign);
            fail_o   = 1'b1;
          end else begin
            ctl_o.ikind = (char_i == stl_pkg::ChDollar) ? stl_pkg::IdDeclare
                                                        : stl_pkg::IdAssign;
            ctl_o.mode  = stl_pkg::ModeIdent;
            ctl_o.skip  = 1'b1;
            tstart_o    = pos_inc;
          end
        end else if (char_i == stl_pkg::ChHash) begin
          ctl_o.mode = stl_pkg::ModeComment;
        end else if (!stl_pkg::is_space(char_i)) begin
          res_o[1] = stl_pkg::tok(stl_pkg::KindError, pos16, 16'd0, stl_pkg::ErrBadChar);
          fail_o   = 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/stl_result_buf.sv =====
// Result register: holds the tokens of one item and hands them out in order.
`include "script_token_lexer_assert.svh"

module stl_result_buf (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  stl_pkg::slot_t [stl_pkg::NumSlots-1:0] load_data_i,
  output logic                                can_load_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output stl_pkg::tok_out_t                   out_data_o
);

  stl_pkg::tok_out_t                slot_q [stl_pkg::NumSlots];
  logic [stl_pkg::NumSlots-1:0]     vld_q, vld_d;
  logic [stl_pkg::SlotIdxW-1:0]     head;
  logic                             last_one;
  logic                             any_load;

  // Lowest valid slot goes out first.
  always_comb begin
    head = '0;
    for (int i = stl_pkg::NumSlots - 1; i >= 0; i--) begin
      if (vld_q[i]) head = stl_pkg::SlotIdxW'(i);
    end
  end

  assign last_one    = ($countones(vld_q) == 1);
  assign out_valid_o = |vld_q;
  assign can_load_o  = (vld_q == '0) || (last_one && out_ready_i);

  always_comb begin
    out_data_o         = slot_q[head];
    out_data_o.run_end = last_one;
  end

  always_comb begin
    vld_d    = vld_q;
    any_load = 1'b0;
    if (out_valid_o && out_ready_i) vld_d[head] = 1'b0;
    if (load_i) begin
      for (int i = 0; i < stl_pkg::NumSlots; i++) begin
        vld_d[i] = load_data_i[i].vld;
        any_load = any_load | load_data_i[i].vld;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < stl_pkg::NumSlots; i++) begin
        slot_q[i] <= load_data_i[i].tok;
      end
    end
  end

  `STL_NEVER(a_load_when_full, load_i && !can_load_o, "load into a busy result buffer")
  `STL_ASSERT(a_load_shows, (load_i && any_load) |=> out_valid_o, "loaded tokens not shown")
  `STL_ASSERT(a_last_drains, (out_valid_o && out_ready_i && last_one && !load_i) |=> !out_valid_o, "buffer did not drain")

endmodule

// ===== sv/script_token_lexer.sv =====
// Top level of the script token lexer: input register, string state and token output.
`include "script_token_lexer_assert.svh"

// Script token lexer. Feed one code point per transaction on in_data_i, with
// final_char set on the last code point of a string; tokens come back on
// out_data_o as kind, start position and length, one token per transaction,
// and run_end marks the last token caused by an input transaction. The lexer
// holds each character back by one so that it is decided with one character of
// lookahead, so a character's token usually appears when the following
// character arrives; the final character flushes everything and closes the
// string with an end token, or with an error token, after which the consumer
// must drop every token already sent for that string. Later transactions of a
// failed string give no tokens until final_char resets the state. Every input
// transaction is decided combinationally by two chained character deciders
// between the input register and the result register, which shows its first
// token and then hands out that transaction's tokens one per cycle while
// out_ready_i is high, so the sustained rate is one input transaction per
// cycle for items that cause at most one token; after an item that causes n
// tokens (n is at most four), the next item loads only as the last of them is
// taken. POS_BITS sets the position counter width: a string may hold at most
// 2^POS_BITS - 1 code points, and positions are reported in their low 16 bits.
module script_token_lexer #(
  parameter int unsigned POS_BITS = stl_pkg::POS_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stl_pkg::lex_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stl_pkg::tok_out_t  out_data_o
);

  localparam logic [POS_BITS-1:0] PosLimit = {POS_BITS{1'b1}};
  localparam stl_pkg::lex_ctl_t CtlReset = '{mode:  stl_pkg::ModeUndef,
                                             ikind: stl_pkg::IdWord,
                                             skip:  1'b0};

  // Input register
  stl_pkg::lex_in_t in_q;
  logic             in_vld_q, in_vld_d;
  logic             advance;
  logic             can_load;

  // String state
  stl_pkg::lex_ctl_t   ctl_q, ctl_d;
  logic [POS_BITS-1:0] tstart_q, tstart_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [20:0]         held_q, held_d;
  logic                held_vld_q, held_vld_d;
  logic                err_q, err_d;

  // Held-character decision
  stl_pkg::lex_ctl_t          a_ctl;
  logic [POS_BITS-1:0]        a_tstart;
  logic                       a_fail;
  stl_pkg::slot_t [1:0]       a_res;
  logic [POS_BITS-1:0]        a_pos;

  // Final-character decision, taking the state the held character leaves
  stl_pkg::lex_ctl_t          mid_ctl;
  logic [POS_BITS-1:0]        mid_tstart;
  logic                       mid_fail;
  stl_pkg::lex_ctl_t          b_ctl;
  logic [POS_BITS-1:0]        b_tstart;
  logic                       b_fail;
  stl_pkg::slot_t [1:0]       b_res;

  logic [POS_BITS-1:0]        pos_inc;
  logic [15:0]                len16;
  stl_pkg::slot_t [stl_pkg::NumSlots-1:0] slots;

  // Take a new transaction whenever the register is empty or moves on now.
  assign advance    = in_vld_q && can_load;
  assign in_ready_o = !in_vld_q || can_load;
  assign in_vld_d   = (in_valid_i && in_ready_o) ? 1'b1 : (advance ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
  end

  assign a_pos   = pos_q - POS_BITS'(1);
  assign pos_inc = pos_q + POS_BITS'(1);
  assign len16   = 16'(pos_inc);

  stl_lex_char #(.POS_BITS(POS_BITS)) u_lex_held (
    .char_i     (held_q),
    .look_i     (in_q.char_code),
    .look_vld_i (1'b1),
    .pos_i      (a_pos),
    .ctl_i      (ctl_q),
    .tstart_i   (tstart_q),
    .ctl_o      (a_ctl),
    .tstart_o   (a_tstart),
    .fail_o     (a_fail),
    .res_o      (a_res)
  );

  // Without a held character the state passes through untouched.
  assign mid_ctl    = held_vld_q ? a_ctl : ctl_q;
  assign mid_tstart = held_vld_q ? a_tstart : tstart_q;
  assign mid_fail   = held_vld_q && a_fail;

  stl_lex_char #(.POS_BITS(POS_BITS)) u_lex_final (
    .char_i     (in_q.char_code),
    .look_i     ('0),
    .look_vld_i (1'b0),
    .pos_i      (pos_q),
    .ctl_i      (mid_ctl),
    .tstart_i   (mid_tstart),
    .ctl_o      (b_ctl),
    .tstart_o   (b_tstart),
    .fail_o     (b_fail),
    .res_o      (b_res)
  );

  // Slots 0-1: held character, 2-3: final character, 4-5: end of string.
  always_comb begin
    ctl_d      = ctl_q;
    tstart_d   = tstart_q;
    pos_d      = pos_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    err_d      = err_q;
    slots      = '0;
    if (!err_q) begin
      if (pos_q == PosLimit) begin
        slots[0] = stl_pkg::tok(stl_pkg::KindError, 16'(pos_q), 16'd0,
                                stl_pkg::ErrTooLong);
        err_d    = 1'b1;
      end else begin
        if (held_vld_q) slots[1:0] = a_res;
        ctl_d    = mid_ctl;
        tstart_d = mid_tstart;
        if (mid_fail) begin
          err_d = 1'b1;
        end else begin
          held_d     = in_q.char_code;
          held_vld_d = 1'b1;
          pos_d      = pos_inc;
          if (in_q.final_char) begin
            held_vld_d = 1'b0;
            slots[3:2] = b_res;
            ctl_d      = b_ctl;
            tstart_d   = b_tstart;
            if (b_fail) begin
              err_d = 1'b1;
            end else begin
              // Flush whatever token is still open, then close the string; an open string gives an error.
              case (b_ctl.mode)
                stl_pkg::ModeString: begin
                  slots[4] = stl_pkg::tok(stl_pkg::KindError, len16, 16'd0,
                                          stl_pkg::ErrUnterm);
                  err_d    = 1'b1;
                end
                stl_pkg::ModeIdent: begin
                  slots[4] = stl_pkg::tok({2'b00, b_ctl.ikind}, 16'(b_tstart),
                                          16'(pos_inc - b_tstart), stl_pkg::ErrNone);
                  slots[5] = stl_pkg::tok(stl_pkg::KindEnd, len16, 16'd0,
                                          stl_pkg::ErrNone);
                end
                stl_pkg::ModeNumber: begin
                  slots[4] = stl_pkg::tok(stl_pkg::KindNumber, 16'(b_tstart),
                                          16'(pos_inc - b_tstart), stl_pkg::ErrNone);
                  slots[5] = stl_pkg::tok(stl_pkg::KindEnd, len16, 16'd0,
                                          stl_pkg::ErrNone);
                end
                default: begin
                  slots[4] = stl_pkg::tok(stl_pkg::KindEnd, len16, 16'd0,
                                          stl_pkg::ErrNone);
                end
              endcase
            end
          end
        end
      end
    end
    // The last code point always returns the string state to reset.
    if (in_q.final_char) begin
      ctl_d      = CtlReset;
      tstart_d   = '0;
      pos_d      = '0;
      held_d     = '0;
      held_vld_d = 1'b0;
      err_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q      <= CtlReset;
      tstart_q   <= '0;
      pos_q      <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      err_q      <= 1'b0;
    end else if (advance) begin
      ctl_q      <= ctl_d;
      tstart_q   <= tstart_d;
      pos_q      <= pos_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      err_q      <= err_d;
    end
  end

  stl_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .load_data_i (slots),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `STL_ASSERT(a_held_has_pos, held_vld_q |-> (pos_q != '0), "held character without a position")
  `STL_ASSERT(a_final_resets, (advance && in_q.final_char) |=> (pos_q == '0 && !held_vld_q && !err_q), "string state not reset")
  `STL_NEVER(a_skip_mode, ctl_q.skip && (ctl_q.mode == stl_pkg::ModeNumber || ctl_q.mode == stl_pkg::ModeComment), "skip pending in a number or comment")

endmodule
